@@ sv/periodic_task_slot_scheduler_defines.svh @@
// Assertion macros shared by the periodic task slot scheduler RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ptss_pkg.sv @@
// Shared types and constants for the periodic task slot scheduler.
// No dependencies; imported by every module of the block.
package ptss_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_RUN    = 3'd1;
  localparam logic [2:0] FUNC_CREATE = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_SETST  = 3'd4;
  localparam logic [2:0] FUNC_SETPER = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic        run_state;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_id;
    logic       status;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_RUN,
    OP_CREATE,
    OP_DELETE,
    OP_SETST,
    OP_SETPER,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  task_id;
    logic [15:0] period;
    logic        run_state;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] period;
    logic [15:0] countdown;
    logic        stopped;
  } entry_t;

endpackage

@@ sv/periodic_task_slot_scheduler.sv @@
// Periodic task slot scheduler: a table of up to MAX_TASKS periodic tasks. A command word is
// taken when start is high and busy is low; results appear one per cycle on out_data, marked
// by out_strobe, and cannot be held off. Commands pass a two-word queue, so busy rises only
// when two commands wait behind the one in progress. An accepted command is written into the
// queue and reaches the table engine once it is idle. Create and unknown codes finish in the
// idle state. Tick and run walk all count entries, where count is the number of tasks (at most
// MAX_TASKS = 16), one entry per cycle, each updated from a registered read of the table memory.
// Delete, set state and set period walk the table up to the first match, or to its end if none
// matches; a delete then moves the last entry into the matching slot. The final word of a
// command is on the ports in the cycle after the engine finishes it. A run emits one word per
// firing task with a nonzero id and then a finished word; every other command gives one status
// word. All words of one command carry last only on the final one.
module periodic_task_slot_scheduler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ptss_pkg::in_t  in_data,
  output logic           out_strobe,
  output ptss_pkg::out_t out_data
);
  import ptss_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  ptss_front u_front (
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (push_cmd)
  );

  ptss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  ptss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_head     (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

@@ sv/ptss_front.sv @@
// Front end: accepts command words and decodes the function code.
// Depends on ptss_pkg; feeds ptss_queue.
module ptss_front (
  input  logic             start,
  output logic             busy,
  input  ptss_pkg::in_t    in_data,
  input  ptss_pkg::q_stat_t q_stat,
  output logic             push,
  output ptss_pkg::cmd_t   cmd
);
  import ptss_pkg::*;

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    cmd.task_id   = in_data.task_id;
    cmd.period    = in_data.period;
    cmd.run_state = in_data.run_state;
    unique case (in_data.func)
      FUNC_TICK:   cmd.op = OP_TICK;
      FUNC_RUN:    cmd.op = OP_RUN;
      FUNC_CREATE: cmd.op = OP_CREATE;
      FUNC_DELETE: cmd.op = OP_DELETE;
      FUNC_SETST:  cmd.op = OP_SETST;
      FUNC_SETPER: cmd.op = OP_SETPER;
      default:     cmd.op = OP_BAD;
    endcase
  end

endmodule

@@ sv/ptss_queue.sv @@
// Short command queue between the decoder and the table engine.
// Depends on ptss_pkg.
module ptss_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ptss_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output ptss_pkg::cmd_t    head,
  output ptss_pkg::q_stat_t q_stat
);
  import ptss_pkg::*;

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/ptss_back.sv @@
// Table engine: holds the task table and carries out queued commands.
// Depends on ptss_pkg and the assertion macros header.
`include "periodic_task_slot_scheduler_defines.svh"

module ptss_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ptss_pkg::q_stat_t q_stat,
  input  ptss_pkg::cmd_t    q_head,
  output logic              pop,
  output logic              out_strobe,
  output ptss_pkg::out_t    out_data
);
  import ptss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_DELRD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             dv_r, dv_nxt;
  logic [IDX_W-1:0] d_idx_r, d_idx_nxt;
  logic [IDX_W-1:0] match_r, match_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_r, out_nxt;

  entry_t           mem [MAX_TASKS];
  entry_t           rdata_r;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wdata;
  logic             more;
  logic [CNT_W-1:0] last_cnt;

  function automatic out_t mk_out(logic [1:0] k, logic [7:0] id, logic st, logic lst);
    out_t o;
    o.kind     = k;
    o.fired_id = id;
    o.status   = st;
    o.last     = lst;
    return o;
  endfunction

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
  assign more       = (rd_idx_r < count_r);
  assign last_cnt   = count_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    dv_nxt         = 1'b0;
    d_idx_nxt      = d_idx_r;
    match_nxt      = match_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = d_idx_r;
    wdata          = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          cmd_nxt    = q_head;
          rd_idx_nxt = '0;
          case (q_head.op)
            OP_CREATE: begin
              out_strobe_nxt = 1'b1;
              if (count_r < CNT_W'(MAX_TASKS)) begin
                wr_en           = 1'b1;
                wr_addr         = count_r[IDX_W-1:0];
                wdata.id        = q_head.task_id;
                wdata.period    = q_head.period;
                wdata.countdown = q_head.period;
                wdata.stopped   = 1'b0;
                count_nxt       = count_r + CNT_W'(1);
                out_nxt         = mk_out(KIND_STATUS, 8'd0, STAT_OK, 1'b1);
              end else begin
                out_nxt = mk_out(KIND_STATUS, 8'd0, STAT_FAIL, 1'b1);
              end
            end
            OP_BAD: begin
              out_strobe_nxt = 1'b1;
              out_nxt        = mk_out(KIND_STATUS, 8'd0, STAT_FAIL, 1'b1);
            end
            default: begin
              state_nxt = S_WALK;
            end
          endcase
        end
      end

      S_WALK: begin
        // Reads run one entry ahead of the entry being updated.
        if (more) begin
          rd_en      = 1'b1;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          dv_nxt     = 1'b1;
          d_idx_nxt  = rd_idx_r[IDX_W-1:0];
        end
        if (dv_r) begin
          case (cmd_r.op)
            OP_TICK: begin
              if (rdata_r.countdown != 16'd0) begin
                wr_en           = 1'b1;
                wdata.countdown = rdata_r.countdown - 16'd1;
              end
            end
            OP_RUN: begin
              if (rdata_r.countdown == 16'd0 && !rdata_r.stopped) begin
                wr_en           = 1'b1;
                wdata.countdown = rdata_r.period;
                if (rdata_r.id != 8'd0) begin
                  out_strobe_nxt = 1'b1;
                  out_nxt        = mk_out(KIND_FIRED, rdata_r.id, STAT_OK, 1'b0);
                end
              end
            end
            default: begin
              if (rdata_r.id == cmd_r.task_id) begin
                dv_nxt = 1'b0;
                if (cmd_r.op == OP_DELETE) begin
                  // Fetch the last entry; it moves into the matching slot.
                  match_nxt = d_idx_r;
                  rd_en     = 1'b1;
                  rd_addr   = last_cnt[IDX_W-1:0];
                  state_nxt = S_DELRD;
                end else begin
                  wr_en = 1'b1;
                  if (cmd_r.op == OP_SETST) begin
                    wdata.stopped = cmd_r.run_state;
                  end else begin
                    wdata.period    = cmd_r.period;
                    wdata.countdown = cmd_r.period;
                  end
                  out_strobe_nxt = 1'b1;
                  out_nxt        = mk_out(KIND_STATUS, 8'd0, STAT_OK, 1'b1);
                  state_nxt      = S_IDLE;
                end
              end
            end
          endcase
        end else if (!more) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
          case (cmd_r.op)
            OP_TICK: out_nxt = mk_out(KIND_STATUS, 8'd0, STAT_OK, 1'b1);
            OP_RUN:  out_nxt = mk_out(KIND_DONE, 8'd0, STAT_OK, 1'b1);
            default: out_nxt = mk_out(KIND_STATUS, 8'd0, STAT_FAIL, 1'b1);
          endcase
        end
      end

      S_DELRD: begin
        wr_en          = 1'b1;
        wr_addr        = match_r;
        wdata          = rdata_r;
        count_nxt      = last_cnt;
        out_strobe_nxt = 1'b1;
        out_nxt        = mk_out(KIND_STATUS, 8'd0, STAT_OK, 1'b1);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      rd_idx_r     <= '0;
      dv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      dv_r         <= dv_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    d_idx_r <= d_idx_nxt;
    match_r <= match_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  `PTSS_ASSERT_SAME(a_count_range, 1'b1, count_r <= CNT_W'(MAX_TASKS), "task count out of range")
  `PTSS_ASSERT_SAME(a_fired_not_last, out_strobe_r && out_r.kind == KIND_FIRED, !out_r.last && out_r.status == STAT_OK, "fired word marked last or failed")
  `PTSS_ASSERT_NEXT(a_walk_ends_last, state_r == S_WALK && state_nxt == S_IDLE, out_strobe_r && out_r.last, "walk ended without a final word")
  `PTSS_ASSERT_NEXT(a_delete_status, state_r == S_DELRD, out_strobe_r && out_r.last && out_r.kind == KIND_STATUS && out_r.status == STAT_OK, "delete did not report ok")

endmodule
